### sv/wep_pkg.sv
// ----------------------------------------------------------------------------
// wep_pkg: shared types and constants of the weighted event picker
// Widths of the cumulative sums, the random fraction and the stream payloads.
// ----------------------------------------------------------------------------
`default_nettype none

package wep_pkg;

	localparam int SUM_BITS      = 40;
	localparam int FRAC_BITS     = 32;
	localparam int HI_BITS       = SUM_BITS - FRAC_BITS;
	localparam int RATE_IN_BITS  = 32;
	localparam int INDEX_BITS    = 9;
	localparam int IN_DATA_BITS  = RATE_IN_BITS + FRAC_BITS;
	localparam int IN_USER_BITS  = 2;
	localparam int OUT_DATA_BITS = 16;

	typedef logic [SUM_BITS-1:0] sum_t;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_PICK = 1'b1
	} op_t;

endpackage

`default_nettype wire

### sv/wep_target.sv
// ----------------------------------------------------------------------------
// wep_target: search target from fraction and total
// target = floor(frac * total / 2^32), split into two products over two stages.
// ----------------------------------------------------------------------------
`default_nettype none

module wep_target (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	input  wire logic [wep_pkg::FRAC_BITS-1:0] frac,
	input  wire wep_pkg::sum_t                 total,
	output logic                               out_valid,
	output wep_pkg::sum_t                      target
);

	localparam int FB = wep_pkg::FRAC_BITS;
	localparam int HB = wep_pkg::HI_BITS;

	logic                 vld_s1;
	logic                 vld_s2;
	logic [2*FB-1:0]      plo_s1;
	logic [FB+HB-1:0]     phi_s1;
	wep_pkg::sum_t        target_s2;
	logic [FB+HB:0]       sum_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	// low and high words of the total, each against the full fraction
	always_ff @(posedge clk) begin
		plo_s1 <= {{FB{1'b0}}, frac} * {{FB{1'b0}}, total[FB-1:0]};
		phi_s1 <= {{HB{1'b0}}, frac} * {{FB{1'b0}}, total[wep_pkg::SUM_BITS-1:FB]};
	end

	// result never exceeds the total, so it fits the sum width
	assign sum_w = {1'b0, phi_s1} + (FB+HB+1)'(plo_s1[2*FB-1:FB]);

	always_ff @(posedge clk) begin
		target_s2 <= sum_w[wep_pkg::SUM_BITS-1:0];
	end

	assign out_valid = vld_s2;
	assign target    = target_s2;

endmodule

`default_nettype wire

### sv/wep_cell.sv
// ----------------------------------------------------------------------------
// wep_cell: one level of the search chain
// Holds the cumulative entries tested at its level, decides one index bit
// and hands the partial index and target to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module wep_cell #(
	parameter int LEVEL    = 0,
	parameter int IDX_BITS = 8,
	parameter int CNT_BITS = 9
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic [IDX_BITS-1:0] wr_idx,
	input  wire wep_pkg::sum_t       wr_data,
	input  wire logic [CNT_BITS-1:0] count,
	input  wire logic                in_valid,
	input  wire logic [IDX_BITS-1:0] in_idx,
	input  wire wep_pkg::sum_t       in_target,
	output logic                     out_valid,
	output logic [IDX_BITS-1:0]      out_idx,
	output wep_pkg::sum_t            out_target
);

	// index bit decided here
	localparam int SH = IDX_BITS - 1 - LEVEL;
	localparam int AW = (LEVEL == 0) ? 1 : LEVEL;
	localparam logic [IDX_BITS-1:0] LOW_ONES = IDX_BITS'((1 << SH) - 1);

	wep_pkg::sum_t         mem [2**AW];
	wep_pkg::sum_t         rd_q;
	logic                  vld_s1;
	logic [IDX_BITS-1:0]   idx_s1;
	wep_pkg::sum_t         tgt_s1;
	logic                  in_range_s1;
	logic                  vld_q;
	logic [IDX_BITS-1:0]   idx_q;
	wep_pkg::sum_t         tgt_q;

	logic                  owns;
	logic [AW-1:0]         wr_addr;
	logic [AW-1:0]         rd_addr;
	logic [IDX_BITS-1:0]   tested;
	logic                  lt;

	// an entry lives at the level given by its count of trailing ones
	assign owns    = wr_en && ((wr_idx & LOW_ONES) == LOW_ONES) && !wr_idx[SH];
	assign wr_addr = AW'(wr_idx >> (SH + 1));
	assign rd_addr = AW'(in_idx >> (SH + 1));
	assign tested  = in_idx | LOW_ONES;

	always_ff @(posedge clk) begin
		if (owns) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		idx_s1      <= in_idx;
		tgt_s1      <= in_target;
		in_range_s1 <= CNT_BITS'(tested) < count;
	end

	// entries past the count act as infinitely large
	assign lt = in_range_s1 && (rd_q < tgt_s1);

	always_ff @(posedge clk) begin
		idx_q <= idx_s1 | (IDX_BITS'(lt) << SH);
		tgt_q <= tgt_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_q  <= vld_s1;
		end
	end

	assign out_valid  = vld_q;
	assign out_idx    = idx_q;
	assign out_target = tgt_q;

endmodule

`default_nettype wire

### sv/weighted_event_picker_core.sv
// ----------------------------------------------------------------------------
// weighted_event_picker_core: roulette-wheel event selection
// Loads build a table of cumulative rates; a pick scales a random fraction by
// the total and returns the first index whose cumulative sum reaches it.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                 tuser
// s_axis   in   [31:0] rate, [63:32] random_fraction  [0] op, [1] first
// m_axis   out  [8:0] sel_index, zero filled          [0] past_end
//
// a load gives no result; the next request can follow at once
// a pick passes the target product, then each search cell in turn (registered
// read, compare) and then the output register before its result is offered
// one pick is in flight at a time; loads are taken while a result waits on m_axis,
// but not while a stalled result is held in a spare register; no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_event_picker_core #(
	parameter int MAX_PROCESSES = 256,
	parameter int RATE_BITS     = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire logic [wep_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,  // rate, random_fraction
	input  wire logic [wep_pkg::IN_USER_BITS-1:0]  s_axis_tuser,  // op, first
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	output logic [wep_pkg::OUT_DATA_BITS-1:0]      m_axis_tdata,  // sel_index
	output logic                                   m_axis_tuser   // past_end
);

	localparam int IDX_BITS = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
	localparam int CNT_BITS = $clog2(MAX_PROCESSES + 1);
	localparam int RU       = (RATE_BITS < wep_pkg::RATE_IN_BITS) ? RATE_BITS
	                          : wep_pkg::RATE_IN_BITS;
	localparam int SB       = wep_pkg::SUM_BITS;
	localparam int IB       = wep_pkg::INDEX_BITS;

	logic                       busy_q;
	logic                       out_valid_q;
	logic                       pend_q;
	logic [IDX_BITS-1:0]        out_idx_q;
	logic                       out_end_q;
	logic [IDX_BITS-1:0]        pend_idx_q;
	logic                       pend_end_q;
	logic [CNT_BITS-1:0]        count_q;
	wep_pkg::sum_t              running_q;

	logic                       accept;
	logic                       is_pick;
	logic                       is_load;
	logic                       first;
	logic [RU-1:0]              rate_used;
	logic [wep_pkg::FRAC_BITS-1:0] frac;
	logic [CNT_BITS-1:0]        base_count;
	wep_pkg::sum_t              base_sum;
	logic [SB:0]                sum_w;
	wep_pkg::sum_t              new_sum;
	logic                       room;
	logic                       wr_en;

	logic                       tgt_valid;
	wep_pkg::sum_t              tgt;
	logic                       vld   [IDX_BITS+1];
	logic [IDX_BITS-1:0]        idx   [IDX_BITS+1];
	wep_pkg::sum_t              tgts  [IDX_BITS+1];
	logic                       res_vld;
	logic                       res_end;
	logic                       out_free;
	logic                       take_res;
	logic                       park_res;
	logic                       move_pend;

	assign s_axis_tready = !busy_q && !pend_q;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_pick       = accept && (wep_pkg::op_t'(s_axis_tuser[0]) == wep_pkg::OP_PICK);
	assign is_load       = accept && (wep_pkg::op_t'(s_axis_tuser[0]) == wep_pkg::OP_LOAD);
	assign first         = s_axis_tuser[1];
	assign rate_used     = s_axis_tdata[RU-1:0];
	assign frac          = s_axis_tdata[wep_pkg::IN_DATA_BITS-1:wep_pkg::RATE_IN_BITS];

	// a first flag restarts the table before the rate is added
	assign base_count = first ? '0 : count_q;
	assign base_sum   = first ? '0 : running_q;
	assign room       = base_count < CNT_BITS'(MAX_PROCESSES);
	assign sum_w      = {1'b0, base_sum} + (SB+1)'(rate_used);
	assign new_sum    = sum_w[SB] ? {SB{1'b1}} : sum_w[SB-1:0];
	assign wr_en      = is_load && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			running_q <= '0;
		end else if (is_load) begin
			if (room) begin
				count_q   <= base_count + CNT_BITS'(1);
				running_q <= new_sum;
			end else begin
				count_q   <= base_count;
				running_q <= base_sum;
			end
		end
	end

	// running sum always equals the last cumulative entry
	wep_target u_target (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (is_pick),
		.frac      (frac),
		.total     (running_q),
		.out_valid (tgt_valid),
		.target    (tgt)
	);

	assign vld[0]  = tgt_valid;
	assign idx[0]  = '0;
	assign tgts[0] = tgt;

	for (genvar k = 0; k < IDX_BITS; k++) begin : g_cell
		wep_cell #(
			.LEVEL    (k),
			.IDX_BITS (IDX_BITS),
			.CNT_BITS (CNT_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.wr_en      (wr_en),
			.wr_idx     (base_count[IDX_BITS-1:0]),
			.wr_data    (new_sum),
			.count      (count_q),
			.in_valid   (vld[k]),
			.in_idx     (idx[k]),
			.in_target  (tgts[k]),
			.out_valid  (vld[k+1]),
			.out_idx    (idx[k+1]),
			.out_target (tgts[k+1])
		);
	end

	assign res_vld   = vld[IDX_BITS];
	assign res_end   = (count_q == '0);
	assign out_free  = !out_valid_q || m_axis_tready;
	assign take_res  = res_vld && out_free;
	assign park_res  = res_vld && !out_free;
	assign move_pend = pend_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (is_pick) begin
				busy_q <= 1'b1;
			end else if (res_vld) begin
				busy_q <= 1'b0;
			end
			if (take_res || move_pend) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (park_res) begin
				pend_q <= 1'b1;
			end else if (move_pend) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_res) begin
			out_idx_q <= idx[IDX_BITS];
			out_end_q <= res_end;
		end else if (move_pend) begin
			out_idx_q <= pend_idx_q;
			out_end_q <= pend_end_q;
		end
		if (park_res) begin
			pend_idx_q <= idx[IDX_BITS];
			pend_end_q <= res_end;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = wep_pkg::OUT_DATA_BITS'(IB'(out_idx_q));
	assign m_axis_tuser  = out_end_q;

	a_pend_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q)
		else $error("held result without a result on the output");

	a_pick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		is_pick |=> busy_q)
		else $error("pick taken without marking the search busy");

	a_result_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld |-> busy_q && !pend_q)
		else $error("search result with no pick in flight");

	a_index_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld && !res_end |-> CNT_BITS'(idx[IDX_BITS]) < count_q)
		else $error("picked index beyond the loaded entries");

	a_end_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("empty table answer carries a nonzero index");

endmodule

`default_nettype wire
